// ===== hdl/ospu_pkg.sv =====
// ----------------------------------------------------------------------------
// Operand stack permute unit - shared definitions
// Command and status codes, stream packing widths, per-command stack needs.
// ----------------------------------------------------------------------------
package ospu_pkg;

    localparam int CMD_W       = 4;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;   // command + push_value, padded to bytes
    localparam int M_TDATA_W   = 40;   // top_value + stack_count + status, padded

    // result field positions in m_tdata
    localparam int TOP_LSB     = 0;
    localparam int CNT_LSB     = TOP_LSB + VAL_W;
    localparam int STATUS_LSB  = CNT_LSB + CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 4'd0,
        CMD_POP     = 4'd1,
        CMD_POP2    = 4'd2,
        CMD_DUP     = 4'd3,
        CMD_DUP_X1  = 4'd4,
        CMD_DUP_X2  = 4'd5,
        CMD_DUP2    = 4'd6,
        CMD_DUP2_X1 = 4'd7,
        CMD_DUP2_X2 = 4'd8,
        CMD_SWAP    = 4'd9
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // live slots a command reads
    function automatic logic [2:0] need_slots(input logic [CMD_W-1:0] cmd);
        case (cmd)
            CMD_PUSH:    need_slots = 3'd0;
            CMD_POP:     need_slots = 3'd1;
            CMD_POP2:    need_slots = 3'd2;
            CMD_DUP:     need_slots = 3'd1;
            CMD_DUP_X1:  need_slots = 3'd2;
            CMD_DUP_X2:  need_slots = 3'd3;
            CMD_DUP2:    need_slots = 3'd2;
            CMD_DUP2_X1: need_slots = 3'd3;
            CMD_DUP2_X2: need_slots = 3'd4;
            CMD_SWAP:    need_slots = 3'd2;
            default:     need_slots = 3'd0;
        endcase
    endfunction

    // net change of the depth
    function automatic logic signed [2:0] grow_slots(input logic [CMD_W-1:0] cmd);
        case (cmd)
            CMD_PUSH:    grow_slots = 3'sd1;
            CMD_POP:     grow_slots = -3'sd1;
            CMD_POP2:    grow_slots = -3'sd2;
            CMD_DUP:     grow_slots = 3'sd1;
            CMD_DUP_X1:  grow_slots = 3'sd1;
            CMD_DUP_X2:  grow_slots = 3'sd1;
            CMD_DUP2:    grow_slots = 3'sd2;
            CMD_DUP2_X1: grow_slots = 3'sd2;
            CMD_DUP2_X2: grow_slots = 3'sd2;
            CMD_SWAP:    grow_slots = 3'sd0;
            default:     grow_slots = 3'sd0;
        endcase
    endfunction

endpackage

// ===== hdl/operand_stack_permute_unit.sv =====
// ----------------------------------------------------------------------------
// Operand stack permute unit
// Bounded operand stack running push, pop, pop2, the dup family and swap.
//
//   channel | dir | tdata fields (lsb first)                    | per transfer
//   s_      | in  | command[3:0], push_value[35:4]              | one command
//   m_      | out | top_value[31:0], stack_count[36:32],        | one result
//           |     | status[38:37]                               |
//
// One command per cycle while s_tready is high; its result is registered on
// m_, or in the skid while m_ stalls. The stack registers update at the
// accepting edge, so the next command sees the new stack at once. A two-entry
// output stage (register + skid) keeps s_tready high until two results wait.
// Reset empties the stack and the output stage; slot contents are not reset.
// ----------------------------------------------------------------------------
module operand_stack_permute_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int SLOT_WIDTH  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ospu_pkg::S_TDATA_W-1:0]  s_tdata,   // command, push_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ospu_pkg::M_TDATA_W-1:0]  m_tdata    // top_value, stack_count, status
);
    import ospu_pkg::*;

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int OVR_N = 6;   // top entries a dup can rewrite

    typedef enum logic [2:0] {
        SH_NONE, SH_UP1, SH_UP2, SH_DN1, SH_DN2
    } shift_t;

    // source select for the rewritten top entries
    typedef enum logic [2:0] {
        SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_PUSH
    } src_t;

    logic [SLOT_WIDTH-1:0] slot_reg  [STACK_DEPTH];
    logic [SLOT_WIDTH-1:0] slot_next [STACK_DEPTH];
    logic [PW-1:0]         cnt_reg;
    logic [PW-1:0]         cnt_next;

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic [M_TDATA_W-1:0]  out_reg;
    logic [M_TDATA_W-1:0]  skid_reg;

    logic [CMD_W-1:0]      cmd;
    logic [VAL_W-1:0]      pv;
    logic [SLOT_WIDTH+VAL_W-1:0] pv_wide;
    logic [SLOT_WIDTH-1:0] pv_slot;
    logic                  accept;
    logic                  underflow;
    logic                  overflow;
    logic                  commit;
    logic signed [PW+1:0]  after_cnt;
    status_t               status;
    shift_t                shift;
    logic [OVR_N-1:0]      ovr_en;
    src_t                  ovr_src [OVR_N];
    logic [SLOT_WIDTH-1:0] shifted;
    logic [SLOT_WIDTH-1:0] ovr_val;
    logic [SLOT_WIDTH-1:0] top_slot;
    logic [SLOT_WIDTH+VAL_W-1:0] top_wide;
    logic [PW+CNT_W-1:0]   cnt_wide;
    logic [M_TDATA_W-1:0]  result;
    logic                  out_free;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign accept   = s_tvalid && s_tready;

    assign cmd     = s_tdata[CMD_W-1:0];
    assign pv      = s_tdata[CMD_W +: VAL_W];
    assign pv_wide = {{SLOT_WIDTH{1'b0}}, pv};
    assign pv_slot = pv_wide[SLOT_WIDTH-1:0];

    assign after_cnt = $signed({2'b00, cnt_reg}) + (PW+2)'(grow_slots(cmd));
    assign underflow = cnt_reg < PW'(need_slots(cmd));
    assign overflow  = after_cnt > $signed((PW+2)'(STACK_DEPTH));
    assign commit    = !underflow && !overflow;

    always_comb begin
        if (underflow) begin
            status = ST_UNDERFLOW;
        end else if (overflow) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_OK;
        end
    end

    // shift of the deep part and rewrites of the top window, top at index 0
    always_comb begin
        shift  = SH_NONE;
        ovr_en = '0;
        for (int k = 0; k < OVR_N; k++) begin
            ovr_src[k] = SRC_T0;
        end
        case (cmd)
            CMD_PUSH: begin
                shift = SH_UP1;
                ovr_en[0] = 1'b1; ovr_src[0] = SRC_PUSH;
            end
            CMD_POP:  shift = SH_DN1;
            CMD_POP2: shift = SH_DN2;
            CMD_DUP: begin
                shift = SH_UP1;
                ovr_en[0] = 1'b1; ovr_src[0] = SRC_T0;
            end
            CMD_DUP_X1: begin
                shift = SH_UP1;
                ovr_en[2:0] = 3'b111;
                ovr_src[0] = SRC_T0; ovr_src[1] = SRC_T1; ovr_src[2] = SRC_T0;
            end
            CMD_DUP_X2: begin
                shift = SH_UP1;
                ovr_en[3:0] = 4'b1111;
                ovr_src[0] = SRC_T0; ovr_src[1] = SRC_T1;
                ovr_src[2] = SRC_T2; ovr_src[3] = SRC_T0;
            end
            CMD_DUP2: begin
                shift = SH_UP2;
                ovr_en[1:0] = 2'b11;
                ovr_src[0] = SRC_T0; ovr_src[1] = SRC_T1;
            end
            CMD_DUP2_X1: begin
                shift = SH_UP2;
                ovr_en[4:0] = 5'b11111;
                ovr_src[0] = SRC_T0; ovr_src[1] = SRC_T1; ovr_src[2] = SRC_T2;
                ovr_src[3] = SRC_T0; ovr_src[4] = SRC_T1;
            end
            CMD_DUP2_X2: begin
                shift = SH_UP2;
                ovr_en = 6'b111111;
                ovr_src[0] = SRC_T0; ovr_src[1] = SRC_T1; ovr_src[2] = SRC_T2;
                ovr_src[3] = SRC_T3; ovr_src[4] = SRC_T0; ovr_src[5] = SRC_T1;
            end
            CMD_SWAP: begin
                ovr_en[1:0] = 2'b11;
                ovr_src[0] = SRC_T1; ovr_src[1] = SRC_T0;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            shifted = slot_reg[i];
            case (shift)
                SH_UP1: if (i >= 1) shifted = slot_reg[i-1];
                SH_UP2: if (i >= 2) shifted = slot_reg[i-2];
                SH_DN1: if (i + 1 < STACK_DEPTH) shifted = slot_reg[i+1];
                SH_DN2: if (i + 2 < STACK_DEPTH) shifted = slot_reg[i+2];
                default: ;
            endcase
            ovr_val = slot_reg[0];
            slot_next[i] = shifted;
            if (i < OVR_N) begin
                case (ovr_src[i])
                    SRC_T0:   ovr_val = slot_reg[0];
                    SRC_T1:   ovr_val = slot_reg[1];
                    SRC_T2:   ovr_val = slot_reg[2];
                    SRC_T3:   ovr_val = slot_reg[3];
                    SRC_PUSH: ovr_val = pv_slot;
                    default:  ovr_val = slot_reg[0];
                endcase
                if (ovr_en[i]) slot_next[i] = ovr_val;
            end
            if (!commit) slot_next[i] = slot_reg[i];
        end
    end

    assign cnt_next = commit ? after_cnt[PW-1:0] : cnt_reg;
    assign top_slot = (cnt_next != '0) ? slot_next[0] : '0;
    assign top_wide = {{VAL_W{1'b0}}, top_slot};
    assign cnt_wide = {{CNT_W{1'b0}}, cnt_next};
    assign result   = {{(M_TDATA_W-STATUS_LSB-STATUS_W){1'b0}}, status,
                       cnt_wide[CNT_W-1:0], top_wide[VAL_W-1:0]};

    // new result lands in the output register if it is empty or drains this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg <= cnt_next;
            end
            if (accept && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= skid_valid_reg;
            end
            if (accept && !out_free) begin
                skid_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_tready && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
        if (accept) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                slot_reg[i] <= slot_next[i];
            end
            if (out_free) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

endmodule

// ===== hdl/ospu_checker.sv =====
// ----------------------------------------------------------------------------
// Operand stack permute unit - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ospu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ospu_pkg::S_TDATA_W-1:0]  s_tdata,   // command, push_value
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ospu_pkg::M_TDATA_W-1:0]  m_tdata    // top_value, stack_count, status
);
    import ospu_pkg::*;

    // output stage empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // after every command transfer, a result is valid on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after command transfer");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a waiting command holds
    a_cmd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("command changed while waiting");

    // status is one of ok, underflow, overflow; padding stays zero
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STATUS_LSB +: STATUS_W] != 2'd3)
                     && (m_tdata[M_TDATA_W-1] == 1'b0))
        else $error("bad status code or padding");

endmodule

bind operand_stack_permute_unit ospu_checker u_ospu_checker (.*);
